FILE: sv/rth_pkg.sv
// Shared types and constants for the RGB to hue/chroma/value pixel unit.
// No dependencies; used by every module of the unit.
`timescale 1ns / 1ps

package rth_pkg;

    localparam int PIX_W  = 8;   // channel width
    localparam int NUM_W  = 14;  // width of 43 * |d|, at most 10965
    localparam int QUOT_W = 6;   // quotient width, quotient is at most 43

    localparam logic [PIX_W-1:0] HUE_OFS_RED   = 8'd0;
    localparam logic [PIX_W-1:0] HUE_OFS_GREEN = 8'd85;
    localparam logic [PIX_W-1:0] HUE_OFS_BLUE  = 8'd170;

    // Channel that holds the maximum
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // Payload handed from cell to cell through the divider row
    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [QUOT_W-1:0] quot;
        logic [PIX_W-1:0]  chroma;
        logic [PIX_W-1:0]  vmax;
        logic              neg;
        t_sector           sector;
        logic              last;
    } t_div_data;

    // Multiply an 8-bit magnitude by the hue scale of 43 (32 + 8 + 2 + 1)
    function automatic logic [NUM_W-1:0] scale_43(input logic [PIX_W-1:0] mag);
        logic [NUM_W-1:0] m;
        m = NUM_W'(mag);
        return (m << 5) + (m << 3) + (m << 1) + m;
    endfunction

endpackage

FILE: sv/rth_front.sv
// Front of the pixel unit: finds max/min channel, signed difference, chroma
// and the scaled dividend in two register stages. Depends on rth_pkg.
`timescale 1ns / 1ps

module rth_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rth_pkg::PIX_W-1:0]   i_red,
    input  logic [rth_pkg::PIX_W-1:0]   i_green,
    input  logic [rth_pkg::PIX_W-1:0]   i_blue,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output rth_pkg::t_div_data          o_data
);

    // Stage one registers
    logic                       r_s1_valid;
    logic [rth_pkg::PIX_W-1:0]  r_s1_vmax;
    logic [rth_pkg::PIX_W-1:0]  r_s1_vmin;
    logic [rth_pkg::PIX_W-1:0]  r_s1_mag;
    logic                       r_s1_neg;
    rth_pkg::t_sector           r_s1_sector;
    logic                       r_s1_last;

    // Stage two registers
    logic                       r_s2_valid;
    rth_pkg::t_div_data         r_s2_data;

    logic                       s1_adv;
    logic                       s2_adv;
    rth_pkg::t_sector           n_sector;
    logic [rth_pkg::PIX_W-1:0]  n_vmax;
    logic [rth_pkg::PIX_W-1:0]  n_vmin;
    logic [rth_pkg::PIX_W:0]    n_diff;
    logic [rth_pkg::PIX_W-1:0]  n_mag;
    rth_pkg::t_div_data         n_s2_data;

    assign s2_adv  = !r_s2_valid || i_ready;
    assign s1_adv  = !r_s1_valid || s2_adv;
    assign o_ready = s1_adv;
    assign o_valid = r_s2_valid;
    assign o_data  = r_s2_data;

    // Classify the pixel: ties go to red, then green
    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_sector = rth_pkg::SEC_RED;
            n_vmax   = i_red;
            n_diff   = {1'b0, i_green} - {1'b0, i_blue};
        end else if (i_green >= i_blue) begin
            n_sector = rth_pkg::SEC_GREEN;
            n_vmax   = i_green;
            n_diff   = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            n_sector = rth_pkg::SEC_BLUE;
            n_vmax   = i_blue;
            n_diff   = {1'b0, i_red} - {1'b0, i_green};
        end
        n_vmin = i_red;
        if (i_green < n_vmin) begin
            n_vmin = i_green;
        end
        if (i_blue < n_vmin) begin
            n_vmin = i_blue;
        end
        n_mag = n_diff[rth_pkg::PIX_W] ? rth_pkg::PIX_W'(-n_diff) : n_diff[rth_pkg::PIX_W-1:0];
    end

    // Build the dividend and chroma for the divider row
    always_comb begin
        n_s2_data        = '0;
        n_s2_data.rem    = rth_pkg::scale_43(r_s1_mag);
        n_s2_data.quot   = '0;
        n_s2_data.chroma = r_s1_vmax - r_s1_vmin;
        n_s2_data.vmax   = r_s1_vmax;
        n_s2_data.neg    = r_s1_neg;
        n_s2_data.sector = r_s1_sector;
        n_s2_data.last   = r_s1_last;
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_valid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Load payloads on transfer
    always_ff @(posedge i_clk) begin
        if (s1_adv && i_valid) begin
            r_s1_vmax   <= n_vmax;
            r_s1_vmin   <= n_vmin;
            r_s1_mag    <= n_mag;
            r_s1_neg    <= n_diff[rth_pkg::PIX_W];
            r_s1_sector <= n_sector;
            r_s1_last   <= i_last;
        end
        if (s2_adv && r_s1_valid) begin
            r_s2_data <= n_s2_data;
        end
    end

endmodule

FILE: sv/rth_div_cell.sv
// One cell of the restoring divider row: resolves one quotient bit per pass.
// Depends on rth_pkg.
`timescale 1ns / 1ps

module rth_div_cell #(
    parameter int BIT = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rth_pkg::t_div_data  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rth_pkg::t_div_data  o_data
);

    logic                           r_valid;
    rth_pkg::t_div_data             r_data;
    logic                           adv;
    logic [rth_pkg::NUM_W-1:0]      shifted;
    logic                           fits;
    rth_pkg::t_div_data             n_data;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Trial subtract of the chroma weighted by this cell's bit
    always_comb begin
        shifted     = rth_pkg::NUM_W'(i_data.chroma) << BIT;
        fits        = i_data.rem >= shifted;
        n_data      = i_data;
        n_data.quot = {i_data.quot[rth_pkg::QUOT_W-2:0], fits};
        if (fits) begin
            n_data.rem = i_data.rem - shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: sv/rth_finish.sv
// Output stage: applies sign, sector offset and zero-chroma rule, and holds
// the result for the consumer. Depends on rth_pkg.
`timescale 1ns / 1ps

module rth_finish (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  rth_pkg::t_div_data          i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [rth_pkg::PIX_W-1:0]   o_hue,
    output logic [rth_pkg::PIX_W-1:0]   o_chroma,
    output logic [rth_pkg::PIX_W-1:0]   o_value,
    output logic                        o_last
);

    logic                       r_valid;
    logic                       adv;
    logic [rth_pkg::PIX_W-1:0]  q;
    logic [rth_pkg::PIX_W-1:0]  ofs;
    logic [rth_pkg::PIX_W-1:0]  n_hue;

    assign adv     = !r_valid || !i_stall;
    assign o_ready = adv;
    assign o_valid = r_valid;

    // Signed quotient plus sector offset, wrapped to 8 bits; zero chroma gives hue zero
    always_comb begin
        q = rth_pkg::PIX_W'(i_data.quot);
        case (i_data.sector)
            rth_pkg::SEC_RED:   ofs = rth_pkg::HUE_OFS_RED;
            rth_pkg::SEC_GREEN: ofs = rth_pkg::HUE_OFS_GREEN;
            rth_pkg::SEC_BLUE:  ofs = rth_pkg::HUE_OFS_BLUE;
            default:            ofs = rth_pkg::HUE_OFS_RED;
        endcase
        if (i_data.chroma == '0) begin
            n_hue = '0;
        end else if (i_data.neg) begin
            n_hue = ofs - q;
        end else begin
            n_hue = ofs + q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            o_hue    <= n_hue;
            o_chroma <= i_data.chroma;
            o_value  <= i_data.vmax;
            o_last   <= i_data.last;
        end
    end

endmodule

FILE: sv/rgb_to_hsv_pixel_unit.sv
// RGB to hue/chroma/value pixel unit, top level. Depends on rth_pkg,
// rth_front, rth_div_cell and rth_finish.
// Pipeline: 2 front stages, one divider cell per quotient bit (6), 1 output stage.
// Throughput: one pixel per cycle while the output is not stalled; each divider cell resolves one quotient bit.
// Reset: synchronous active-low reset empties the pipeline; no other state.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic        i_last_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_hue_out,
    output logic [7:0]  o_chroma_out,
    output logic [7:0]  o_value_out,
    output logic        o_last_out
);

    localparam int NC = rth_pkg::QUOT_W;

    logic                   front_ready;
    logic                   w_valid [NC+1];
    logic                   w_ready [NC+1];
    rth_pkg::t_div_data     w_data  [NC+1];

    assign o_stall = !front_ready;

    rth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (front_ready),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .i_last  (i_last_pixel),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    // Divider row, most significant quotient bit first
    for (genvar k = 0; k < NC; k++) begin : g_cell
        rth_div_cell #(
            .BIT (NC - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    rth_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[NC]),
        .o_ready  (w_ready[NC]),
        .i_data   (w_data[NC]),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_hue    (o_hue_out),
        .o_chroma (o_chroma_out),
        .o_value  (o_value_out),
        .o_last   (o_last_out)
    );

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for rgb_to_hsv_pixel_unit.
// Drives directed and random pixels through the valid/stall handshake,
// predicts every hue/chroma/value result and checks them in order.
// Depends on rth_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int PIX_W            = rth_pkg::PIX_W;
    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 7;
    localparam int HUE_SIXTH        = 43;      // hue steps per sixth of the circle
    localparam int DRAIN_CYCLES     = 16;
    localparam int CYCLE_LIMIT      = 250000;
    localparam int MAX_REPORTS      = 10;
    localparam int RANDOM_PIXELS    = 1000;
    localparam int FOCUSED_PIXELS   = 650;
    localparam int FULL_RATE_PIXELS = 300;

    // One hue/chroma/value result
    typedef struct packed {
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] chroma;
        logic [PIX_W-1:0] vmax;
        logic             last;
    } t_hsv_result;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_valid      = 1'b0;
    logic             o_stall;
    logic [PIX_W-1:0] i_red_in     = '0;
    logic [PIX_W-1:0] i_green_in   = '0;
    logic [PIX_W-1:0] i_blue_in    = '0;
    logic             i_last_pixel = 1'b0;
    logic             o_valid;
    logic             i_stall      = 1'b0;
    logic [PIX_W-1:0] o_hue_out;
    logic [PIX_W-1:0] o_chroma_out;
    logic [PIX_W-1:0] o_value_out;
    logic             o_last_out;

    t_hsv_result expected_hsv[$];
    logic        bursts_on      = 1'b1;
    int          pixels_sent    = 0;
    int          results_seen   = 0;
    int          zero_chroma    = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          stall_left     = 0;

    rgb_to_hsv_pixel_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_last_pixel (i_last_pixel),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue_out    (o_hue_out),
        .o_chroma_out (o_chroma_out),
        .o_value_out  (o_value_out),
        .o_last_out   (o_last_out)
    );

    // Toggle the clock every half period
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Compute hue, chroma and value of one pixel
    function automatic t_hsv_result predict_hsv(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b,
                                                input logic             last);
        t_hsv_result      res;
        rth_pkg::t_sector sector;
        logic [PIX_W-1:0] vmin;
        logic [PIX_W-1:0] ofs;
        int               diff;
        int               mag;
        int               quot;
        vmin = r;
        if (g < vmin) vmin = g;
        if (b < vmin) vmin = b;
        // Ties resolve to the earlier channel: red, then green, then blue
        if (r >= g && r >= b) sector = rth_pkg::SEC_RED;
        else if (g >= b)      sector = rth_pkg::SEC_GREEN;
        else                  sector = rth_pkg::SEC_BLUE;
        case (sector)
            rth_pkg::SEC_RED: begin
                res.vmax = r;
                diff     = int'(g) - int'(b);
                ofs      = rth_pkg::HUE_OFS_RED;
            end
            rth_pkg::SEC_GREEN: begin
                res.vmax = g;
                diff     = int'(b) - int'(r);
                ofs      = rth_pkg::HUE_OFS_GREEN;
            end
            default: begin
                res.vmax = b;
                diff     = int'(r) - int'(g);
                ofs      = rth_pkg::HUE_OFS_BLUE;
            end
        endcase
        res.chroma = res.vmax - vmin;
        res.last   = last;
        // Gray pixels have no hue; otherwise truncate toward zero and wrap
        if (res.chroma == '0) begin
            res.hue = '0;
        end else begin
            mag  = (diff < 0) ? -diff : diff;
            quot = (HUE_SIXTH * mag) / int'(res.chroma);
            if (diff < 0) quot = -quot;
            res.hue = PIX_W'(quot + int'(ofs));
        end
        return res;
    endfunction

    // Offer one pixel, after an optional idle burst, and hold it until the transfer
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input logic last);
        int gap;
        gap = 0;
        if (bursts_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_red_in     <= r;
        i_green_in   <= g;
        i_blue_in    <= b;
        i_last_pixel <= last;
        do @(posedge i_clk); while (o_stall);
        expected_hsv.push_back(predict_hsv(r, g, b, last));
        if (r == g && g == b) zero_chroma++;
        pixels_sent++;
    endtask

    // Stall the result side in random bursts while enabled
    always @(negedge i_clk) begin
        if (!bursts_on) begin
            stall_left = 0;
            i_stall   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Check each result transfer against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_hsv_result got;
        t_hsv_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{hue: o_hue_out, chroma: o_chroma_out, vmax: o_value_out,
                    last: o_last_out};
            results_seen++;
            if (expected_hsv.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: hue %0d chroma %0d value %0d last %0b",
                             $time, got.hue, got.chroma, got.vmax, got.last);
            end else begin
                want = expected_hsv.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("[%0t] mismatch: expected hue %0d chroma %0d value %0d last %0b",
                                 $time, want.hue, want.chroma, want.vmax, want.last);
                        $display("[%0t]           got hue %0d chroma %0d value %0d last %0b",
                                 $time, got.hue, got.chroma, got.vmax, got.last);
                    end
                end
            end
        end
    end

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_hsv.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Corners: black, white, primaries, ties, wrapped red hue, chroma of one
    task automatic test_extremes();
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd1,   1'b0);
        send_pixel(8'd200, 8'd10,  8'd100, 1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
        send_pixel(8'd1,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd1,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd1,   1'b1);
        send_pixel(8'd100, 8'd50,  8'd50,  1'b0);
        send_pixel(8'd254, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd254, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd254, 8'd0,   1'b0);
        send_pixel(8'd170, 8'd85,  8'd0,   1'b1);
        send_pixel(8'd0,   8'd170, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd1,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd0,   1'b1);
    endtask

    // Uniform random pixels with idling on both sides
    task automatic test_random_pixels();
        repeat (RANDOM_PIXELS)
            send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                       1'($urandom));
    endtask

    // Pixels near the sector borders: small chroma, ties, gray, full swing
    task automatic test_sector_borders();
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] ch[3];
        int               mode;
        int               pick;
        repeat (FOCUSED_PIXELS) begin
            base = PIX_W'($urandom);
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 3; k++) ch[k] = PIX_W'($urandom);
            case (mode)
                0: for (int k = 0; k < 3; k++)
                       ch[k] = (int'(base) + $urandom_range(0, 3) > 255) ?
                               base : PIX_W'(int'(base) + $urandom_range(0, 3));
                1: begin
                    pick = $urandom_range(0, 2);
                    ch[pick] = ch[(pick + 1) % 3];
                end
                2: for (int k = 0; k < 3; k++) ch[k] = base;
                default: begin
                    pick = $urandom_range(0, 2);
                    ch[pick]           = 8'd255;
                    ch[(pick + 1) % 3] = 8'd0;
                end
            endcase
            send_pixel(ch[0], ch[1], ch[2], 1'($urandom));
        end
    endtask

    // Back-to-back pixels with no idling on either side
    task automatic test_full_rate();
        bursts_on = 1'b0;
        repeat (FULL_RATE_PIXELS)
            send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                       1'($urandom));
    endtask

    initial begin
        // Hold reset, then release on a falling edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_random_pixels();
        test_sector_borders();
        test_full_rate();

        // Drop valid and drain the pipeline
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_hsv.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_hsv.size() != 0) mismatch_count += expected_hsv.size();
        $display("Sent %0d pixels (%0d gray), checked %0d results, %0d mismatches.",
                 pixels_sent, zero_chroma, results_seen, mismatch_count);
        $display("Covered corners, sector ties, random and full-rate traffic.");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
